>>> src/mbrtu_pkg.sv
// shared types, constants and crc helper for the modbus rtu request framer
package mbrtu_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int CRC_BYTES   = 6;
    localparam int HDR_W       = 8 * CRC_BYTES;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_LSB  = 16'h0001;
    localparam logic [2:0]  LAST_POS = 3'd7;
    localparam logic [2:0]  FIRST_POS = 3'd0;

    // request as it travels down the crc pipeline
    typedef struct packed {
        logic [HDR_W-1:0] frame;   // address in the top byte, count low in the bottom
        logic [HDR_W-1:0] rem;     // bytes still to fold into the crc, next one on top
        logic [15:0]      crc;
    } req_word_t;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if ((c & CRC_LSB) != 16'h0000)
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/mbrtu_if.sv
// valid/ready channel interfaces for requests and frame bytes
interface mbrtu_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  station_address;
    logic [7:0]  opcode;
    logic [15:0] start_register;
    logic [15:0] register_count;

    modport source (output valid, output station_address, output opcode,
                    output start_register, output register_count, input ready);
    modport sink   (input valid, input station_address, input opcode,
                    input start_register, input register_count, output ready);
endinterface

interface mbrtu_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [2:0] byte_position;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input last_byte, output ready);
endinterface

>>> src/mbrtu_crc_stage.sv
// one pipeline stage folding one header byte into the crc
module mbrtu_crc_stage
    import mbrtu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_word_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output req_word_t m_data
);

    logic      valid_reg;
    req_word_t data_reg;
    req_word_t data_next;

    assign s_ready = !valid_reg || m_ready;

    always_comb
    begin
        data_next       = s_data;
        data_next.crc   = crc_byte(s_data.crc, s_data.rem[HDR_W-1 -: 8]);
        data_next.rem   = {s_data.rem[HDR_W-9:0], 8'h00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> src/mbrtu_serializer.sv
// holds a finished frame and sends it out one byte per cycle while the sink is ready
module mbrtu_serializer
    import mbrtu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_word_t s_data,
    mbrtu_frm_if.source frm
);

    logic                         busy_reg;
    logic [2:0]                   pos_reg;
    logic [FRAME_BYTES-1:0][7:0]  frame_reg;
    logic [FRAME_BYTES-1:0][7:0]  frame_next;
    logic                         take_out;
    logic                         at_last;

    assign at_last  = (pos_reg == LAST_POS);
    assign take_out = busy_reg && frm.ready;
    // next request loads as the last byte leaves
    assign s_ready  = !busy_reg || (frm.ready && at_last);

    always_comb
    begin
        frame_next[0] = s_data.frame[47:40];
        frame_next[1] = s_data.frame[39:32];
        frame_next[2] = s_data.frame[31:24];
        frame_next[3] = s_data.frame[23:16];
        frame_next[4] = s_data.frame[15:8];
        frame_next[5] = s_data.frame[7:0];
        frame_next[6] = s_data.crc[7:0];
        frame_next[7] = s_data.crc[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= FIRST_POS;
        end
        else if (s_valid && s_ready)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= FIRST_POS;
        end
        else if (take_out)
        begin
            busy_reg <= !at_last;
            pos_reg  <= pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frm.valid         = busy_reg;
    assign frm.frame_byte    = frame_reg[pos_reg];
    assign frm.byte_position = pos_reg;
    assign frm.last_byte     = at_last;

endmodule

>>> src/modbus_rtu_request_framer.sv
// the first frame byte appears once the request has passed all crc stages and loaded into the serializer
// the crc runs through six register stages, one header byte each
// request rate is set by the one-byte-per-cycle output, which stalls while the sink is not ready
// up to six requests queue in the crc stages while a frame is sent
// reset: asynchronous active low, clears all valid bits; pipeline comes up empty
module modbus_rtu_request_framer
    import mbrtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mbrtu_req_if.sink   req,
    mbrtu_frm_if.source frm
);

    logic      st_valid [CRC_BYTES+1];
    logic      st_ready [CRC_BYTES+1];
    req_word_t st_data  [CRC_BYTES+1];

    always_comb
    begin
        st_data[0].frame = {req.station_address, req.opcode,
                            req.start_register, req.register_count};
        st_data[0].rem   = {req.station_address, req.opcode,
                            req.start_register, req.register_count};
        st_data[0].crc   = CRC_INIT;
    end

    assign st_valid[0] = req.valid;
    assign req.ready   = st_ready[0];

    for (genvar k = 0; k < CRC_BYTES; k++)
    begin : g_crc
        mbrtu_crc_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .s_valid (st_valid[k]),
            .s_ready (st_ready[k]),
            .s_data  (st_data[k]),
            .m_valid (st_valid[k+1]),
            .m_ready (st_ready[k+1]),
            .m_data  (st_data[k+1])
        );
    end

    mbrtu_serializer u_ser (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (st_valid[CRC_BYTES]),
        .s_ready (st_ready[CRC_BYTES]),
        .s_data  (st_data[CRC_BYTES]),
        .frm     (frm)
    );

endmodule

>>> src/mbrtu_checker.sv
// port-level checks on the frame byte stream, bound to the top level
module mbrtu_checker
    import mbrtu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       frm_valid,
    input logic       frm_ready,
    input logic [7:0] frm_byte,
    input logic [2:0] frm_pos,
    input logic       frm_last
);

    // flag sits on the crc high byte only
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid |-> (frm_last == (frm_pos == LAST_POS)))
        else $error("last_byte flag off position seven");

    // inside a frame the next byte follows at once with the next position
    a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frm_ready && !frm_last |=>
            frm_valid && (frm_pos == $past(frm_pos) + 3'd1))
        else $error("frame byte skipped or repeated");

    // a new frame starts at position zero
    a_new_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frm_ready && frm_last |=> !frm_valid || (frm_pos == FIRST_POS))
        else $error("frame does not start at position zero");

    // a stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && !frm_ready |=> frm_valid && $stable(frm_byte) && $stable(frm_pos))
        else $error("stalled frame byte changed");

endmodule

bind modbus_rtu_request_framer mbrtu_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm.valid),
    .frm_ready (frm.ready),
    .frm_byte  (frm.frame_byte),
    .frm_pos   (frm.byte_position),
    .frm_last  (frm.last_byte)
);

>>> verif/testbench.sv
// testbench for the modbus rtu request framer: directed and random requests, byte-level check
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrtu_pkg::*;

    localparam logic [15:0] MODBUS_CRC_SEED = 16'hFFFF;
    localparam logic [15:0] MODBUS_CRC_POLY = 16'hA001;
    localparam int          RANDOM_REQUESTS = 392;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          DRAIN_CYCLES    = 24;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] pos;
        logic       last;
    } frame_beat_t;

    logic clk;
    logic rst_n;

    mbrtu_req_if req_ch();
    mbrtu_frm_if frm_ch();

    modbus_rtu_request_framer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .frm   (frm_ch)
    );

    frame_beat_t frame_bytes_due[$];
    int          mismatches;
    int          cycle_count;
    bit          src_idle_on;
    bit          snk_idle_on;
    int          snk_stall_left;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // crc-16/modbus over the six header bytes, bit at a time lsb first
    function automatic logic [15:0] modbus_crc(input logic [8*CRC_BYTES-1:0] header);
        logic [15:0] crc;
        logic        fb;
        crc = MODBUS_CRC_SEED;
        for (int k = 0; k < CRC_BYTES; k++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                fb  = crc[0] ^ header[8*k + i];
                crc = crc >> 1;
                if (fb)
                begin
                    crc = crc ^ MODBUS_CRC_POLY;
                end
            end
        end
        return crc;
    endfunction

    // byte k of the frame in bits 8k+7..8k
    function automatic logic [8*FRAME_BYTES-1:0] build_frame(input logic [7:0] addr,
                                                              input logic [7:0] func,
                                                              input logic [15:0] start,
                                                              input logic [15:0] count);
        logic [8*CRC_BYTES-1:0] header;
        logic [15:0]            crc;
        header = {count[7:0], count[15:8], start[7:0], start[15:8], func, addr};
        crc    = modbus_crc(header);
        return {crc[15:8], crc[7:0], header};
    endfunction

    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func,
                               input logic [15:0] start, input logic [15:0] count);
        logic [8*FRAME_BYTES-1:0] frame;
        frame_beat_t              beat;
        frame = build_frame(addr, func, start, count);
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            beat.data = frame[8*k +: 8];
            beat.pos  = k[2:0];
            beat.last = (k[2:0] == LAST_POS);
            frame_bytes_due.push_back(beat);
        end
    endtask

    task automatic send_request(input logic [7:0] addr, input logic [7:0] func,
                                input logic [15:0] start, input logic [15:0] count);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid           = 1'b1;
        req_ch.station_address = addr;
        req_ch.opcode          = func;
        req_ch.start_register  = start;
        req_ch.register_count  = count;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        queue_frame(addr, func, start, count);
    endtask

    task automatic release_request_bus();
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_frames_done();
        while (frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sink stalls
    always @(negedge clk)
    begin
        if (snk_idle_on && snk_stall_left == 0)
        begin
            snk_stall_left = pick_gap();
        end
        if (snk_stall_left > 0)
        begin
            frm_ch.ready   = 1'b0;
            snk_stall_left = snk_stall_left - 1;
        end
        else
        begin
            frm_ch.ready = rst_n;
        end
    end

    always @(posedge clk)
    begin
        frame_beat_t got;
        frame_beat_t want;
        if (rst_n && frm_ch.valid && frm_ch.ready)
        begin
            got.data = frm_ch.frame_byte;
            got.pos  = frm_ch.byte_position;
            got.last = frm_ch.last_byte;
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected frame byte, expected none, got %02h pos %0d last %0b",
                         $realtime, got.data, got.pos, got.last);
                mismatches++;
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (got.data !== want.data)
                begin
                    $display("%0t: frame_byte expected %02h got %02h (pos %0d)",
                             $realtime, want.data, got.data, want.pos);
                    mismatches++;
                end
                if (got.pos !== want.pos)
                begin
                    $display("%0t: byte_position expected %0d got %0d",
                             $realtime, want.pos, got.pos);
                    mismatches++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last_byte expected %0b got %0b (pos %0d)",
                             $realtime, want.last, got.last, want.pos);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_field_extremes();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
        send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(8'hAA, 8'h55, 16'hAAAA, 16'h5555);
        send_request(8'h55, 8'hAA, 16'h5555, 16'hAAAA);
        send_request(8'h01, 8'h03, 16'h0000, 16'h000A);
        send_request(8'h11, 8'h04, 16'h006B, 16'h0003);
        send_request(8'h80, 8'h01, 16'h8000, 16'h0001);
        send_request(8'hFF, 8'h00, 16'h00FF, 16'hFF00);
        send_request(8'h00, 8'hFF, 16'hFF00, 16'h00FF);
        send_request(8'hF7, 8'h10, 16'h0001, 16'h8000);
        release_request_bus();
        wait_frames_done();
    endtask

    // repeated and changing requests with no gaps on either side
    task automatic test_back_to_back();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_request(8'h01, 8'h03, 16'h1234, 16'h0010);
        send_request(8'h01, 8'h03, 16'h1234, 16'h0010);
        send_request(8'hFE, 8'h06, 16'hFFFF, 16'h0000);
        send_request(8'h02, 8'h0F, 16'h0000, 16'hFFFF);
        send_request(8'h02, 8'h0F, 16'h0000, 16'hFFFF);
        send_request(8'h7F, 8'h02, 16'h7FFF, 16'h7FFF);
        send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
        send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        release_request_bus();
        wait_frames_done();
    endtask

    task automatic test_random_requests();
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] start;
        logic [15:0] count;
        logic [7:0]  common_funcs[8];
        int          mode;
        int          r;
        common_funcs = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0F, 8'h10};
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // switch idle pattern every few dozen requests
            if (n % 40 == 0)
            begin
                mode        = $urandom_range(0, 3);
                src_idle_on = (mode == 0) || (mode == 2);
                snk_idle_on = (mode == 0) || (mode == 3);
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                addr  = 8'($urandom_range(0, 255));
                func  = 8'($urandom_range(0, 255));
                start = 16'($urandom_range(0, 65535));
                count = 16'($urandom_range(0, 65535));
            end
            else if (r < 85)
            begin
                addr  = 8'($urandom_range(1, 247));
                func  = common_funcs[3'($urandom_range(0, 7))];
                start = 16'($urandom_range(0, 65535));
                count = 16'($urandom_range(1, 125));
            end
            else
            begin
                addr  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                func  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                start = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            send_request(addr, func, start, count);
        end
        release_request_bus();
        wait_frames_done();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.station_address = 8'h00;
        req_ch.opcode          = 8'h00;
        req_ch.start_register  = 16'h0000;
        req_ch.register_count  = 16'h0000;
        frm_ch.ready           = 1'b0;
        mismatches             = 0;
        cycle_count            = 0;
        src_idle_on            = 1'b0;
        snk_idle_on            = 1'b0;
        snk_stall_left         = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_back_to_back();
        test_random_requests();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
